[rtl/cga_pkg.sv]
package cga_pkg;

	localparam int PORT_W    = 16;
	localparam int BYTE_W    = 8;
	localparam int ELAPSED_W = 12;
	localparam int FRAME_W   = 25;
	localparam int LINE_NS_W = 16;
	localparam int LINE_W    = 13;
	localparam int COLOR_W   = 4;
	localparam int RGB_W     = 24;
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = FRAME_W;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_LOAD  = 2'd3
	} cmd_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_FRAME_LEN     = 3'd0,
		CFG_LINE_LEN      = 3'd1,
		CFG_VISIBLE_LINES = 3'd2,
		CFG_ACTIVE_WIDTH  = 3'd3,
		CFG_RETRACE_FIRST = 3'd4,
		CFG_RETRACE_COUNT = 3'd5,
		CFG_BLINK_LOCK    = 3'd6
	} cfg_idx_t;

	localparam logic [PORT_W-1:0] PORT_MONO_MODE  = 16'h03B8;
	localparam logic [PORT_W-1:0] PORT_MONO_CFG   = 16'h03BF;
	localparam logic [PORT_W-1:0] PORT_MODE_CTRL  = 16'h03D8;
	localparam logic [PORT_W-1:0] PORT_COLOR_SEL  = 16'h03D9;

	localparam logic [BYTE_W-1:0] MODE_CO80       = 8'h03;
	localparam logic [BYTE_W-1:0] MODE_GFX4       = 8'h04;
	localparam logic [BYTE_W-1:0] MODE_GFX5       = 8'h05;
	localparam logic [BYTE_W-1:0] MODE_GFX6       = 8'h06;
	localparam logic [BYTE_W-1:0] MODE_MONO_TEXT  = 8'h07;
	localparam logic [BYTE_W-1:0] MODE_MONO_GFX   = 8'h1e;
	localparam logic [BYTE_W-1:0] MODE_TEXT_REMAP = 8'h0a;
	localparam logic [BYTE_W-1:0] MODE_LORES16    = 8'h77;
	localparam logic [BYTE_W-1:0] MODE_GFX_REMAP  = 8'h76;
	localparam logic [BYTE_W-1:0] CTRL_HIRES_TEXT = 8'h1b;
	localparam logic [3:0]        CTRL_LO_LORES16 = 4'h1;
	localparam logic [3:0]        CTRL_LO_GFX6    = 4'ha;
	localparam logic [4:0]        CTRL_LO_GFX_REM = 5'h1a;

	localparam logic [BYTE_W-1:0] BLINK_ON_MASK   = 8'h7F;
	localparam logic [BYTE_W-1:0] BLINK_OFF_MASK  = 8'hFF;
	localparam logic [BYTE_W-1:0] STATUS_MONO     = 8'hFF;
	localparam int                STATUS_INACTIVE = 0;
	localparam int                STATUS_VRETRACE = 3;

	localparam logic [1:0] CSET_ALT = 2'd2;

	localparam logic [FRAME_W-1:0]   RST_FRAME_LEN     = 25'd16666667;
	localparam logic [LINE_NS_W-1:0] RST_LINE_LEN      = 16'd63613;
	localparam logic [LINE_W-1:0]    RST_VISIBLE_LINES = 13'd200;
	localparam logic [LINE_NS_W-1:0] RST_ACTIVE_WIDTH  = 16'd52600;
	localparam logic [LINE_W-1:0]    RST_RETRACE_FIRST = 13'd224;
	localparam logic [LINE_W-1:0]    RST_RETRACE_COUNT = 13'd16;
	localparam logic [COLOR_W-1:0]   RST_FOREGROUND    = 4'd15;

	localparam logic [COLOR_W-1:0] GFX_SET [3][2][4] = '{
		'{ '{4'd0, 4'd2, 4'd4, 4'd6}, '{4'd0, 4'd10, 4'd12, 4'd14} },
		'{ '{4'd0, 4'd3, 4'd5, 4'd7}, '{4'd0, 4'd11, 4'd13, 4'd15} },
		'{ '{4'd0, 4'd3, 4'd4, 4'd7}, '{4'd0, 4'd11, 4'd12, 4'd15} }
	};

	function automatic logic [COLOR_W-1:0] set_entry(logic [1:0] cset, logic inten,
		logic [1:0] idx);
		logic [1:0] cs;
		cs = (cset == 2'd3) ? CSET_ALT : cset;
		return GFX_SET[cs][inten][idx];
	endfunction

	function automatic logic [RGB_W-1:0] rgb_of(logic [COLOR_W-1:0] idx);
		logic [RGB_W-1:0] rgb;
		case (idx)
			4'd0:    rgb = 24'h000000;
			4'd1:    rgb = 24'h0000C4;
			4'd2:    rgb = 24'h00C400;
			4'd3:    rgb = 24'h00C4C4;
			4'd4:    rgb = 24'hC40000;
			4'd5:    rgb = 24'hC400C4;
			4'd6:    rgb = 24'hC47E00;
			4'd7:    rgb = 24'hC4C4C4;
			4'd8:    rgb = 24'h4E4E4E;
			4'd9:    rgb = 24'h4E4EDC;
			4'd10:   rgb = 24'h4EDC4E;
			4'd11:   rgb = 24'h4EF3F3;
			4'd12:   rgb = 24'hDC4E4E;
			4'd13:   rgb = 24'hF34EF3;
			4'd14:   rgb = 24'hF3F34E;
			default: rgb = 24'hFFFFFF;
		endcase
		return rgb;
	endfunction

endpackage

[rtl/cga_if.sv]
interface cga_req_if;
	logic                           valid;
	logic                           ready;
	cga_pkg::cmd_t                  cmd;
	logic [cga_pkg::PORT_W-1:0]     port;
	logic [cga_pkg::BYTE_W-1:0]     value;
	logic [cga_pkg::ELAPSED_W-1:0]  elapsed_ns;
	logic [cga_pkg::BYTE_W-1:0]     mode_value;

	modport source(output valid, cmd, port, value, elapsed_ns, mode_value, input ready);
	modport sink(input valid, cmd, port, value, elapsed_ns, mode_value, output ready);
endinterface

interface cga_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [cga_pkg::BYTE_W-1:0]    read_data;
	logic [cga_pkg::BYTE_W-1:0]    video_mode;
	logic [cga_pkg::RGB_W-1:0]     palette_rgb_0;
	logic [cga_pkg::RGB_W-1:0]     palette_rgb_1;
	logic [cga_pkg::RGB_W-1:0]     palette_rgb_2;
	logic [cga_pkg::RGB_W-1:0]     palette_rgb_3;
	logic                          hires_flag;
	logic                          burst_bit;
	logic [cga_pkg::BYTE_W-1:0]    blink_attr_mask;
	logic                          mono_active;
	logic [cga_pkg::COLOR_W-1:0]   foreground_index;

	modport source(output valid, read_data, video_mode, palette_rgb_0, palette_rgb_1,
		palette_rgb_2, palette_rgb_3, hires_flag, burst_bit, blink_attr_mask,
		mono_active, foreground_index, input ready);
	modport sink(input valid, read_data, video_mode, palette_rgb_0, palette_rgb_1,
		palette_rgb_2, palette_rgb_3, hires_flag, burst_bit, blink_attr_mask,
		mono_active, foreground_index, output ready);
endinterface

interface cga_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [cga_pkg::CFG_ADDR_W-1:0]    addr;
	logic [cga_pkg::CFG_DATA_W-1:0]    data;

	modport source(output valid, addr, data, input ready);
	modport sink(input valid, addr, data, output ready);
endinterface

[rtl/cga_mode_palette_status_registers.sv]
// Mode control, color select and raster status registers of a color
// graphics adapter, with monochrome-card takeover.
// req: one beat per bus access, raster tick or firmware mode load (cmd).
// rsp: one beat per req beat, in order: status byte for a read (0 for the
//   other commands), mode number, four palette colors as RGB and the mode,
//   blink and color register fields as they stand after the beat.
// cfg: register writes (frame/line timing, retrace window, blink lock), always
//   ready; the user must have them written while the block is idle; not enforced.
// Path: an accepted req beat sits in the input stage until the result
//   register is free; its rsp beat is then loaded there and offered.
// Throughput: one beat per cycle while rsp.ready holds; the whole update
//   is one pass of compare, add/subtract and palette lookup between the
//   input stage and the result register.
// Stall: while rsp is held, the result register keeps its beat, the input
//   stage keeps one more, and req.ready drops only when both are full.
// Reset: all mode, color and raster counters return to their power-on
//   values, timing registers to their defaults, and both stages empty.
module cga_mode_palette_status_registers (
	input  logic         clk,
	input  logic         arst_n,
	cga_req_if.sink      req,
	cga_rsp_if.source    rsp,
	cga_cfg_if.sink      cfg
);

	localparam int FP_W = cga_pkg::FRAME_W + 1;
	localparam int LP_W = cga_pkg::LINE_NS_W + 1;

	// timing registers
	logic [cga_pkg::FRAME_W-1:0]   frame_len_q;
	logic [cga_pkg::LINE_NS_W-1:0] line_len_q;
	logic [cga_pkg::LINE_W-1:0]    visible_q;
	logic [cga_pkg::LINE_NS_W-1:0] active_q;
	logic [cga_pkg::LINE_W-1:0]    retrace_first_q;
	logic [cga_pkg::LINE_W-1:0]    retrace_count_q;
	logic                          blink_lock_q;

	// input stage
	logic                            valid_s1;
	cga_pkg::cmd_t                   cmd_s1;
	logic [cga_pkg::PORT_W-1:0]      port_s1;
	logic [cga_pkg::BYTE_W-1:0]      value_s1;
	logic [cga_pkg::ELAPSED_W-1:0]   elapsed_s1;
	logic [cga_pkg::BYTE_W-1:0]      mode_value_s1;

	// state
	logic [cga_pkg::BYTE_W-1:0]    mode_q, mode_d;
	logic [1:0]                    mono_en_q, mono_en_d;
	logic                          mono_q, mono_d;
	logic                          hires_q, hires_d;
	logic                          burst_q, burst_d;
	logic [1:0]                    cset_q, cset_d;
	logic                          inten_q, inten_d;
	logic [cga_pkg::COLOR_W-1:0]   fg_q, fg_d;
	logic [cga_pkg::BYTE_W-1:0]    blink_mask_q, blink_mask_d;
	logic [cga_pkg::COLOR_W-1:0]   pal_q [4];
	logic [cga_pkg::COLOR_W-1:0]   pal_d [4];
	logic [cga_pkg::FRAME_W-1:0]   frame_q, frame_d;
	logic [cga_pkg::LINE_W-1:0]    lnum_q, lnum_d;
	logic [cga_pkg::LINE_NS_W-1:0] lphase_q, lphase_d;

	// result register
	logic                          out_valid_q;
	logic [cga_pkg::BYTE_W-1:0]    rd_q;
	logic [cga_pkg::BYTE_W-1:0]    rd_d;
	logic [cga_pkg::BYTE_W-1:0]    out_mode_q;
	logic [cga_pkg::RGB_W-1:0]     out_rgb_q [4];
	logic                          out_hires_q;
	logic                          out_burst_q;
	logic [cga_pkg::BYTE_W-1:0]    out_blink_q;
	logic                          out_mono_q;
	logic [cga_pkg::COLOR_W-1:0]   out_fg_q;

	logic                          out_free;
	logic                          adv;
	logic                          req_acc;

	// raster / tick datapath
	logic [FP_W-1:0]               fp_sum, fp_t;
	logic [LP_W-1:0]               lp_sum, lp_t;
	logic [cga_pkg::LINE_W-1:0]    lnum_t;
	logic [cga_pkg::LINE_W:0]      retrace_end;
	logic                          disp_inactive;
	logic                          vretrace;
	logic [cga_pkg::BYTE_W-1:0]    status;

	assign out_free  = !out_valid_q || rsp.ready;
	assign adv       = valid_s1 && out_free;
	assign req.ready = !valid_s1 || out_free;
	assign req_acc   = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_len_q     <= cga_pkg::RST_FRAME_LEN;
			line_len_q      <= cga_pkg::RST_LINE_LEN;
			visible_q       <= cga_pkg::RST_VISIBLE_LINES;
			active_q        <= cga_pkg::RST_ACTIVE_WIDTH;
			retrace_first_q <= cga_pkg::RST_RETRACE_FIRST;
			retrace_count_q <= cga_pkg::RST_RETRACE_COUNT;
			blink_lock_q    <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.addr)
				cga_pkg::CFG_FRAME_LEN:     frame_len_q <= cfg.data;
				cga_pkg::CFG_LINE_LEN:      line_len_q <= cfg.data[cga_pkg::LINE_NS_W-1:0];
				cga_pkg::CFG_VISIBLE_LINES: visible_q <= cfg.data[cga_pkg::LINE_W-1:0];
				cga_pkg::CFG_ACTIVE_WIDTH:  active_q <= cfg.data[cga_pkg::LINE_NS_W-1:0];
				cga_pkg::CFG_RETRACE_FIRST: retrace_first_q <= cfg.data[cga_pkg::LINE_W-1:0];
				cga_pkg::CFG_RETRACE_COUNT: retrace_count_q <= cfg.data[cga_pkg::LINE_W-1:0];
				cga_pkg::CFG_BLINK_LOCK:    blink_lock_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_acc) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			cmd_s1        <= req.cmd;
			port_s1       <= req.port;
			value_s1      <= req.value;
			elapsed_s1    <= req.elapsed_ns;
			mode_value_s1 <= req.mode_value;
		end
	end

	// raster status from state before the beat
	always_comb begin
		retrace_end   = {1'b0, retrace_first_q} + {1'b0, retrace_count_q};
		disp_inactive = (lnum_q >= visible_q) || (lphase_q >= active_q);
		vretrace      = (lnum_q >= retrace_first_q) && ({1'b0, lnum_q} < retrace_end);
		status        = '0;
		status[cga_pkg::STATUS_INACTIVE] = disp_inactive;
		status[cga_pkg::STATUS_VRETRACE] = vretrace;
	end

	// tick: advance line and frame counters
	always_comb begin
		fp_sum = {1'b0, frame_q} + FP_W'(elapsed_s1);
		lp_sum = {1'b0, lphase_q} + LP_W'(elapsed_s1);
		lp_t   = lp_sum;
		lnum_t = lnum_q;
		if (lp_sum >= {1'b0, line_len_q}) begin
			lp_t = lp_sum - {1'b0, line_len_q};
			if (lp_t >= {1'b0, line_len_q}) begin
				lp_t = '0;
			end
			lnum_t = lnum_q + 1'b1;
		end
		fp_t = fp_sum;
		if (fp_sum >= {1'b0, frame_len_q}) begin
			fp_t = fp_sum - {1'b0, frame_len_q};
			if (fp_t >= {1'b0, frame_len_q}) begin
				fp_t = '0;
			end
			lnum_t = '0;
			lp_t   = (fp_t < FP_W'(line_len_q)) ? fp_t[LP_W-1:0] : '0;
		end
	end

	always_comb begin
		mode_d       = mode_q;
		mono_en_d    = mono_en_q;
		mono_d       = mono_q;
		hires_d      = hires_q;
		burst_d      = burst_q;
		cset_d       = cset_q;
		inten_d      = inten_q;
		fg_d         = fg_q;
		blink_mask_d = blink_mask_q;
		pal_d        = pal_q;
		frame_d      = frame_q;
		lnum_d       = lnum_q;
		lphase_d     = lphase_q;
		rd_d         = '0;
		case (cmd_s1)
			cga_pkg::CMD_WRITE: begin
				case (port_s1)
					cga_pkg::PORT_MONO_MODE: begin
						mono_d = mono_en_q[0] && value_s1[1];
						if (mono_d && mode_q != cga_pkg::MODE_MONO_TEXT) begin
							mode_d = cga_pkg::MODE_MONO_GFX;
						end
					end
					cga_pkg::PORT_MONO_CFG: begin
						mono_en_d = value_s1[1:0];
					end
					cga_pkg::PORT_MODE_CTRL: begin
						hires_d = value_s1[4];
						burst_d = value_s1[2];
						if ((mode_q == cga_pkg::MODE_GFX4 || mode_q == cga_pkg::MODE_GFX5)
							&& burst_d) begin
							cset_d = cga_pkg::CSET_ALT;
						end
						if (mode_d == cga_pkg::MODE_CO80 && value_s1 == cga_pkg::CTRL_HIRES_TEXT) begin
							mode_d = cga_pkg::MODE_TEXT_REMAP;
						end
						if (value_s1[3:0] == cga_pkg::CTRL_LO_LORES16) begin
							mode_d = cga_pkg::MODE_LORES16;
						end
						if (value_s1[4:0] == cga_pkg::CTRL_LO_GFX_REM) begin
							mode_d = cga_pkg::MODE_GFX_REMAP;
						end
						if (mode_d == cga_pkg::MODE_GFX6 && value_s1[3:0] == cga_pkg::CTRL_LO_GFX6) begin
							mode_d = cga_pkg::MODE_GFX_REMAP;
						end
						if (!blink_lock_q) begin
							blink_mask_d = value_s1[5] ? cga_pkg::BLINK_ON_MASK
								: cga_pkg::BLINK_OFF_MASK;
						end
						for (int i = 0; i < 4; i++) begin
							pal_d[i] = cga_pkg::set_entry(cset_d, inten_q, 2'(i));
						end
					end
					cga_pkg::PORT_COLOR_SEL: begin
						fg_d = value_s1[3:0];
						if (!burst_q) begin
							cset_d = {1'b0, value_s1[5]};
						end
						inten_d  = value_s1[4];
						pal_d[0] = fg_d;
						for (int i = 1; i < 4; i++) begin
							pal_d[i] = cga_pkg::set_entry(cset_d, inten_d, 2'(i));
						end
					end
					default: ;
				endcase
			end
			cga_pkg::CMD_READ: begin
				rd_d = mono_q ? cga_pkg::STATUS_MONO : status;
			end
			cga_pkg::CMD_TICK: begin
				frame_d  = fp_t[cga_pkg::FRAME_W-1:0];
				lnum_d   = lnum_t;
				lphase_d = lp_t[cga_pkg::LINE_NS_W-1:0];
			end
			cga_pkg::CMD_LOAD: begin
				mode_d = mode_value_s1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= '0;
			mono_en_q    <= '0;
			mono_q       <= 1'b0;
			hires_q      <= 1'b0;
			burst_q      <= 1'b0;
			cset_q       <= '0;
			inten_q      <= 1'b0;
			fg_q         <= cga_pkg::RST_FOREGROUND;
			blink_mask_q <= cga_pkg::BLINK_OFF_MASK;
			for (int i = 0; i < 4; i++) begin
				pal_q[i] <= '0;
			end
			frame_q      <= '0;
			lnum_q       <= '0;
			lphase_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (adv) begin
				mode_q       <= mode_d;
				mono_en_q    <= mono_en_d;
				mono_q       <= mono_d;
				hires_q      <= hires_d;
				burst_q      <= burst_d;
				cset_q       <= cset_d;
				inten_q      <= inten_d;
				fg_q         <= fg_d;
				blink_mask_q <= blink_mask_d;
				pal_q        <= pal_d;
				frame_q      <= frame_d;
				lnum_q       <= lnum_d;
				lphase_q     <= lphase_d;
				out_valid_q  <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rd_q        <= rd_d;
			out_mode_q  <= mode_d;
			for (int i = 0; i < 4; i++) begin
				out_rgb_q[i] <= cga_pkg::rgb_of(pal_d[i]);
			end
			out_hires_q <= hires_d;
			out_burst_q <= burst_d;
			out_blink_q <= blink_mask_d;
			out_mono_q  <= mono_d;
			out_fg_q    <= fg_d;
		end
	end

	assign rsp.valid            = out_valid_q;
	assign rsp.read_data        = rd_q;
	assign rsp.video_mode       = out_mode_q;
	assign rsp.palette_rgb_0    = out_rgb_q[0];
	assign rsp.palette_rgb_1    = out_rgb_q[1];
	assign rsp.palette_rgb_2    = out_rgb_q[2];
	assign rsp.palette_rgb_3    = out_rgb_q[3];
	assign rsp.hires_flag       = out_hires_q;
	assign rsp.burst_bit        = out_burst_q;
	assign rsp.blink_attr_mask  = out_blink_q;
	assign rsp.mono_active      = out_mono_q;
	assign rsp.foreground_index = out_fg_q;

	// only a read beat carries status
	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && cmd_s1 != cga_pkg::CMD_READ) |=> (rsp.read_data == '0))
		else $error("nonzero read_data on a non-read beat");

	// monochrome takeover masks raster status
	a_rd_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && cmd_s1 == cga_pkg::CMD_READ && mono_q) |=>
		(rsp.read_data == cga_pkg::STATUS_MONO))
		else $error("status read in mono mode not 0xFF");

	a_mode_load: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && cmd_s1 == cga_pkg::CMD_LOAD) |=>
		(rsp.video_mode == $past(mode_value_s1) && mode_q == $past(mode_value_s1)))
		else $error("mode load not reflected");

	a_blink_lock: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && blink_lock_q) |=> $stable(blink_mask_q))
		else $error("blink mask changed while locked");

endmodule
